@@ rtl/core/btgm_pkg.sv @@
package btgm_pkg;

  localparam int unsigned Channels          = 3;
  localparam int unsigned PixW              = 8;
  localparam int unsigned AccW              = 28;
  localparam int unsigned TermW             = 2 * AccW;
  localparam int unsigned ScoreW            = 58;
  localparam int unsigned IdxW              = 11;
  localparam int unsigned GainW             = 16;
  localparam int unsigned MaxTilesDefault   = 1024;
  localparam int unsigned GainFracDefault   = 8;

  localparam logic [AccW-1:0]   AccMax    = {AccW{1'b1}};
  localparam logic [ScoreW-1:0] ScoreOnes = {ScoreW{1'b1}};
  localparam logic [GainW-1:0]  GainMax   = {GainW{1'b1}};

  typedef enum logic [2:0] {
    S_ACC,
    S_MUL,
    S_SUM,
    S_CMP,
    S_DLD,
    S_DIV,
    S_OUT
  } state_e;

  // lane control, driven by the top-level sequencer
  typedef struct packed {
    logic acc_en;
    logic tile_clr;
    logic mul_en;
    logic term_en;
    logic set_clr;
    logic div_load;
    logic div_step;
  } ctrl_t;

endpackage

@@ rtl/core/btgm_if.sv @@
interface btgm_in_if;
  logic                     valid;
  logic                     ready;
  logic [btgm_pkg::PixW-1:0] target_red;
  logic [btgm_pkg::PixW-1:0] target_green;
  logic [btgm_pkg::PixW-1:0] target_blue;
  logic [btgm_pkg::PixW-1:0] tile_red;
  logic [btgm_pkg::PixW-1:0] tile_green;
  logic [btgm_pkg::PixW-1:0] tile_blue;
  logic                     last_of_tile;
  logic                     last_of_set;

  modport source (output valid, target_red, target_green, target_blue, tile_red, tile_green,
                  tile_blue, last_of_tile, last_of_set, input ready);
  modport sink (input valid, target_red, target_green, target_blue, tile_red, tile_green,
                tile_blue, last_of_tile, last_of_set, output ready);
endinterface

interface btgm_out_if;
  logic                         valid;
  logic                         ready;
  logic [btgm_pkg::IdxW-1:0]    best_index;
  logic [btgm_pkg::GainW-1:0]   gain_red;
  logic [btgm_pkg::GainW-1:0]   gain_green;
  logic [btgm_pkg::GainW-1:0]   gain_blue;
  logic                         gain_saturated;
  logic [btgm_pkg::ScoreW-1:0]  best_score;

  modport source (output valid, best_index, gain_red, gain_green, gain_blue, gain_saturated,
                  best_score, input ready);
  modport sink (input valid, best_index, gain_red, gain_green, gain_blue, gain_saturated,
                best_score, output ready);
endinterface

@@ rtl/core/best_tile_gain_match_core.sv @@
// Least-squares gain template match over RGB tiles, three channel lanes plus a merge stage.
// Throughput: one pixel pair per cycle inside a tile; each tile end then passes through the
// multiply, term and merge/compare states, during which no pixel is taken.
// Set end then adds a divider load, the divider steps and an output load, which waits while
// an earlier result is still held unaccepted; out valid is registered from the output load.
// Reset (rst_ni low, async): accumulators and best values cleared, best score all ones.
module best_tile_gain_match_core #(
  parameter int unsigned MAX_TILES      = btgm_pkg::MaxTilesDefault,
  parameter int unsigned GAIN_FRAC_BITS = btgm_pkg::GainFracDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btgm_in_if.sink    in_i,
  btgm_out_if.source out_o
);
  import btgm_pkg::*;

  localparam int unsigned DivSteps = AccW + GAIN_FRAC_BITS;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  state_e state_q, state_d;
  ctrl_t  ctrl;
  logic   in_xfer, set_end_q, merge_en, load_out;
  logic [DivCntW-1:0] div_cnt_q;

  logic [Channels-1:0][PixW-1:0]  tgt, til;
  logic [Channels-1:0][TermW-1:0] term;
  logic [Channels-1:0][GainW-1:0] gain;
  logic [Channels-1:0]            sat;
  logic                           capture;
  logic [ScoreW-1:0]              best_score;
  logic [IdxW-1:0]                best_index, tile_cnt;

  // output register
  logic              out_valid_q;
  logic [IdxW-1:0]   o_idx_q;
  logic [GainW-1:0]  o_gr_q, o_gg_q, o_gb_q;
  logic              o_sat_q;
  logic [ScoreW-1:0] o_score_q;

  assign in_i.ready = (state_q == S_ACC);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign tgt = {in_i.target_blue, in_i.target_green, in_i.target_red};
  assign til = {in_i.tile_blue, in_i.tile_green, in_i.tile_red};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_ACC: if (in_xfer && (in_i.last_of_tile || in_i.last_of_set)) state_d = S_MUL;
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_CMP;
      S_CMP: state_d = set_end_q ? S_DLD : S_ACC;
      S_DLD: state_d = S_DIV;
      S_DIV: if (div_cnt_q == DivCntW'(DivSteps - 1)) state_d = S_OUT;
      S_OUT: if (!out_valid_q || out_o.ready) state_d = S_ACC;
      default: state_d = S_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl     = '0;
    merge_en = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_ACC: ctrl.acc_en = in_xfer;
      S_MUL: ctrl.mul_en = 1'b1;
      S_SUM: ctrl.term_en = 1'b1;
      S_CMP: begin
        merge_en      = 1'b1;
        ctrl.tile_clr = 1'b1;
      end
      S_DLD: ctrl.div_load = 1'b1;
      S_DIV: ctrl.div_step = 1'b1;
      S_OUT: begin
        load_out     = !out_valid_q || out_o.ready;
        ctrl.set_clr = load_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_ACC;
      set_end_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) set_end_q <= in_i.last_of_set;
      if (ctrl.div_load)      div_cnt_q <= '0;
      else if (ctrl.div_step) div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  for (genvar c = 0; c < Channels; c++) begin : g_lane
    btgm_lane #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .capture_i(capture),
      .target_i (tgt[c]),
      .tile_i   (til[c]),
      .term_o   (term[c]),
      .gain_o   (gain[c]),
      .sat_o    (sat[c])
    );
  end

  btgm_merge #(
    .MAX_TILES(MAX_TILES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .merge_en_i  (merge_en),
    .set_clr_i   (ctrl.set_clr),
    .term_i      (term),
    .capture_o   (capture),
    .best_score_o(best_score),
    .best_index_o(best_index),
    .tile_cnt_o  (tile_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_idx_q   <= best_index;
      o_gr_q    <= gain[0];
      o_gg_q    <= gain[1];
      o_gb_q    <= gain[2];
      o_sat_q   <= |sat;
      o_score_q <= best_score;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.best_index     = o_idx_q;
  assign out_o.gain_red       = o_gr_q;
  assign out_o.gain_green     = o_gg_q;
  assign out_o.gain_blue      = o_gb_q;
  assign out_o.gain_saturated = o_sat_q;
  assign out_o.best_score     = o_score_q;

  // every set scores its first tile, so a result never carries index zero
  a_idx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> best_index != '0) else $error("best index zero at result load");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_cnt <= IdxW'(MAX_TILES)) else $error("tile counter past limit");

  a_tile_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.last_of_tile || in_i.last_of_set) |=> !in_i.ready)
    else $error("pixel taken during tile scoring");

  a_capture_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |-> state_q == S_CMP) else $error("best capture outside merge cycle");

endmodule

@@ rtl/core/btgm_lane.sv @@
module btgm_lane #(
  parameter int unsigned GAIN_FRAC_BITS = btgm_pkg::GainFracDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  btgm_pkg::ctrl_t               ctrl_i,
  input  logic                          capture_i,
  input  logic [btgm_pkg::PixW-1:0]     target_i,
  input  logic [btgm_pkg::PixW-1:0]     tile_i,
  output logic [btgm_pkg::TermW-1:0]    term_o,
  output logic [btgm_pkg::GainW-1:0]    gain_o,
  output logic                          sat_o
);
  import btgm_pkg::*;

  localparam int unsigned DvdW = AccW + GAIN_FRAC_BITS;

  logic [AccW-1:0] te_q, pe_q, x_q;
  logic [AccW-1:0] te_d, pe_d, x_d;
  logic [AccW-1:0] bte_q, bx_q;
  logic [TermW-1:0] a_q, b_q, term_q;
  logic [AccW-1:0] rem_q;
  logic [DvdW-1:0] dvd_q, quo_q;
  logic [AccW:0]   rem_sh;
  logic            qbit;

  function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] acc, logic [2*PixW-1:0] v);
    logic [AccW:0] s;
    s = {1'b0, acc} + (AccW+1)'(v);
    return s[AccW] ? AccMax : s[AccW-1:0];
  endfunction

  always_comb begin
    te_d = sat_add(te_q, target_i * target_i);
    pe_d = sat_add(pe_q, tile_i * tile_i);
    x_d  = sat_add(x_q, target_i * tile_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q  <= '0;
      pe_q  <= '0;
      x_q   <= '0;
      bte_q <= '0;
      bx_q  <= '0;
    end else begin
      if (ctrl_i.tile_clr) begin
        te_q <= '0;
        pe_q <= '0;
        x_q  <= '0;
      end else if (ctrl_i.acc_en) begin
        te_q <= te_d;
        pe_q <= pe_d;
        x_q  <= x_d;
      end
      if (ctrl_i.set_clr) begin
        bte_q <= '0;
        bx_q  <= '0;
      end else if (capture_i) begin
        bte_q <= pe_q;
        bx_q  <= x_q;
      end
    end
  end

  // score term: te*pe - x^2, floored at zero
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      a_q <= te_q * pe_q;
      b_q <= x_q * x_q;
    end
    if (ctrl_i.term_en) begin
      term_q <= (a_q > b_q) ? (a_q - b_q) : '0;
    end
  end

  // restoring divider, one quotient bit a cycle; zero divisor yields all ones
  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign qbit   = (rem_sh >= {1'b0, bte_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      rem_q <= '0;
      dvd_q <= DvdW'(bx_q) << GAIN_FRAC_BITS;
      quo_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= qbit ? AccW'(rem_sh - {1'b0, bte_q}) : rem_sh[AccW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      quo_q <= {quo_q[DvdW-2:0], qbit};
    end
  end

  assign sat_o  = (quo_q[DvdW-1:GainW] != '0);
  assign gain_o = sat_o ? GainMax : quo_q[GainW-1:0];
  assign term_o = term_q;

endmodule

@@ rtl/core/btgm_merge.sv @@
module btgm_merge #(
  parameter int unsigned MAX_TILES = btgm_pkg::MaxTilesDefault
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          merge_en_i,
  input  logic                                          set_clr_i,
  input  logic [btgm_pkg::Channels-1:0][btgm_pkg::TermW-1:0] term_i,
  output logic                                          capture_o,
  output logic [btgm_pkg::ScoreW-1:0]                   best_score_o,
  output logic [btgm_pkg::IdxW-1:0]                     best_index_o,
  output logic [btgm_pkg::IdxW-1:0]                     tile_cnt_o
);
  import btgm_pkg::*;

  logic [ScoreW-1:0] best_q, score;
  logic [IdxW-1:0]   cnt_q, idx_q;
  logic              scored;

  assign score     = ScoreW'(term_i[0]) + ScoreW'(term_i[1]) + ScoreW'(term_i[2]);
  assign scored    = (cnt_q < IdxW'(MAX_TILES));
  assign capture_o = merge_en_i && scored && (score < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= ScoreOnes;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (set_clr_i) begin
      best_q <= ScoreOnes;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else if (merge_en_i && scored) begin
      cnt_q <= cnt_q + 1'b1;
      if (capture_o) begin
        best_q <= score;
        idx_q  <= cnt_q + 1'b1;
      end
    end
  end

  assign best_score_o = best_q;
  assign best_index_o = idx_q;
  assign tile_cnt_o   = cnt_q;

endmodule

@@ test/tb.sv @@
module tb;
  import btgm_pkg::*;

  localparam int unsigned TileLimit = MaxTilesDefault;
  localparam int unsigned FracBits  = GainFracDefault;
  // last_of_set transfer to out valid
  localparam int unsigned SetLatency = 5 + AccW + FracBits;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [GainW-1:0]  g_r;
    logic [GainW-1:0]  g_g;
    logic [GainW-1:0]  g_b;
    logic              sat;
    logic [ScoreW-1:0] score;
  } match_t;

  logic clk_i;
  logic rst_ni;

  btgm_in_if  pix_if ();
  btgm_out_if res_if ();

  best_tile_gain_match_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pix_if),
    .out_o (res_if)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // matcher state mirror
  logic [AccW-1:0]   tgt_nrg [Channels];
  logic [AccW-1:0]   cand_nrg[Channels];
  logic [AccW-1:0]   xprod   [Channels];
  logic [AccW-1:0]   win_nrg [Channels];
  logic [AccW-1:0]   win_x   [Channels];
  logic [ScoreW-1:0] win_score;
  logic [IdxW-1:0]   tiles_seen;
  logic [IdxW-1:0]   win_idx;

  match_t pending_matches[$];
  int     mismatch_cnt = 0;
  int     idle_cycles = 0;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_recv;

  function automatic logic [AccW-1:0] acc_sat(logic [AccW-1:0] a, logic [16:0] v);
    logic [AccW:0] s;
    s = a + v;
    return s[AccW] ? AccMax : s[AccW-1:0];
  endfunction

  function automatic logic [GainW-1:0] gain_q(logic [AccW-1:0] x, logic [AccW-1:0] e,
                                              ref logic sat);
    logic [63:0] q;
    if (e == '0) begin
      sat = 1'b1;
      return GainMax;
    end
    q = ({36'b0, x} << FracBits) / e;
    if (q > GainMax) begin
      sat = 1'b1;
      return GainMax;
    end
    return q[GainW-1:0];
  endfunction

  task automatic clear_set();
    win_score  = ScoreOnes;
    tiles_seen = '0;
    win_idx    = '0;
    for (int c = 0; c < Channels; c++) begin
      win_nrg[c] = '0;
      win_x[c]   = '0;
    end
  endtask

  // pixel-pair accumulate, tile scoring and set emission
  task automatic predict_pixel(logic [PixW-1:0] t[3], logic [PixW-1:0] p[3], logic lt,
                               logic ls);
    logic [63:0]  a, b;
    logic [ScoreW-1:0] sc;
    match_t m;
    logic   s;
    for (int c = 0; c < Channels; c++) begin
      tgt_nrg[c]  = acc_sat(tgt_nrg[c], t[c] * t[c]);
      cand_nrg[c] = acc_sat(cand_nrg[c], p[c] * p[c]);
      xprod[c]    = acc_sat(xprod[c], t[c] * p[c]);
    end
    if (lt || ls) begin
      if (tiles_seen < TileLimit) begin
        tiles_seen++;
        sc = '0;
        for (int c = 0; c < Channels; c++) begin
          a = tgt_nrg[c] * cand_nrg[c];
          b = xprod[c] * xprod[c];
          if (a > b) sc += a - b;
        end
        if (sc < win_score) begin
          win_score = sc;
          win_idx   = tiles_seen;
          for (int c = 0; c < Channels; c++) begin
            win_nrg[c] = cand_nrg[c];
            win_x[c]   = xprod[c];
          end
        end
      end
      for (int c = 0; c < Channels; c++) begin
        tgt_nrg[c] = '0; cand_nrg[c] = '0; xprod[c] = '0;
      end
    end
    if (ls) begin
      s       = 1'b0;
      m.idx   = win_idx;
      m.g_r   = gain_q(win_x[0], win_nrg[0], s);
      m.g_g   = gain_q(win_x[1], win_nrg[1], s);
      m.g_b   = gain_q(win_x[2], win_nrg[2], s);
      m.sat   = s;
      m.score = win_score;
      pending_matches.push_back(m);
      clear_set();
    end
  endtask

  // one pixel transfer, with random sender idling; valid stays up until the next idle
  task automatic send_pixel(logic [PixW-1:0] t[3], logic [PixW-1:0] p[3], logic lt, logic ls);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid        <= 1'b1;
    pix_if.target_red   <= t[0];
    pix_if.target_green <= t[1];
    pix_if.target_blue  <= t[2];
    pix_if.tile_red     <= p[0];
    pix_if.tile_green   <= p[1];
    pix_if.tile_blue    <= p[2];
    pix_if.last_of_tile <= lt;
    pix_if.last_of_set  <= ls;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_pixel(t, p, lt, ls);
  endtask

  task automatic send_rand_tile(int npix, logic ls, int style);
    logic [PixW-1:0] t[3], p[3];
    for (int i = 0; i < npix; i++) begin
      for (int c = 0; c < 3; c++) begin
        case (style)
          0: begin t[c] = $urandom; p[c] = $urandom; end
          1: begin t[c] = $urandom; p[c] = t[c] >> $urandom_range(2, 0); end  // good match
          2: begin t[c] = $urandom; p[c] = $urandom_range(1, 0); end          // tiny tile
          default: begin t[c] = 8'hFF; p[c] = 8'hFF; end
        endcase
      end
      send_pixel(t, p, i == npix - 1, ls && i == npix - 1);
    end
  endtask

  task automatic send_rand_set(int ntiles, int maxpix);
    for (int k = 0; k < ntiles; k++)
      send_rand_tile($urandom_range(maxpix, 1), k == ntiles - 1, $urandom_range(2, 0));
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SetLatency + 4) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic [PixW-1:0] z[3], f[3], o[3];
    z = '{0, 0, 0}; f = '{8'hFF, 8'hFF, 8'hFF}; o = '{1, 0, 8'h80};
    send_pixel(f, z, 1'b1, 1'b1);          // zero tile energy, all gains saturate
    send_pixel(z, f, 1'b1, 1'b0);          // zero cross, zero gain
    send_pixel(f, o, 1'b1, 1'b1);          // large red quotient, but the earlier tile wins the zero-score tie
    send_pixel(f, f, 1'b0, 1'b0);
    send_pixel(o, f, 1'b0, 1'b1);          // set end closes an open tile
    send_pixel(f, f, 1'b1, 1'b0);          // equal scores: first wins
    send_pixel(f, f, 1'b1, 1'b1);
    send_pixel(z, z, 1'b1, 1'b1);
  endtask

  task automatic test_random(int npix);
    int start;
    start = 0;
    while (start < npix) begin
      send_rand_set($urandom_range(6, 1), 8);
      start += 30;
      if ($urandom_range(9, 0) == 0) begin
        // noise set: random flags per pixel
        logic [PixW-1:0] t[3], p[3];
        for (int i = 0; i < 10; i++) begin
          for (int c = 0; c < 3; c++) begin t[c] = $urandom; p[c] = $urandom; end
          send_pixel(t, p, $urandom_range(1, 0), $urandom_range(5, 0) == 0);
        end
      end
    end
    send_rand_tile(2, 1'b1, 0);
  endtask

  // receiver holds off while one set of many short tiles streams in
  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      send_rand_set(40, 1);
    join
    wait_drained();
  endtask

  // result checker and receiver idling
  always @(posedge clk_i) begin
    match_t got, exp;
    if (res_if.valid && res_if.ready) begin
      got = '{res_if.best_index, res_if.gain_red, res_if.gain_green, res_if.gain_blue,
              res_if.gain_saturated, res_if.best_score};
      if (pending_matches.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        exp = pending_matches.pop_front();
        if (got !== exp) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: exp %p got %p", exp, got);
        end
      end
    end
    res_if.ready <= !hold_recv && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // watchdog on transfers of either channel
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    hold_recv = 1'b0;
    send_idle_pct = 28; recv_idle_pct = 63;
    rst_ni = 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.target_red <= '0; pix_if.target_green <= '0; pix_if.target_blue <= '0;
    pix_if.tile_red <= '0; pix_if.tile_green <= '0; pix_if.tile_blue <= '0;
    pix_if.last_of_tile <= 1'b0; pix_if.last_of_set <= 1'b0;
    for (int c = 0; c < Channels; c++) begin
      tgt_nrg[c] = '0; cand_nrg[c] = '0; xprod[c] = '0;
    end
    clear_set();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_random(240);
    wait_drained();                        // sender pause until all results are in
    send_idle_pct = 63; recv_idle_pct = 28;
    test_random(240);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(240);
    wait_drained();

    if (mismatch_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ best_tile_gain_match_core.f @@
rtl/core/btgm_pkg.sv
rtl/core/btgm_if.sv
rtl/core/btgm_lane.sv
rtl/core/btgm_merge.sv
rtl/core/best_tile_gain_match_core.sv
test/tb.sv
